// File: rtl/hdt_pkg.sv
package hdt_pkg;

    localparam int CycleWidth   = 8;
    localparam int TickWidth    = CycleWidth - 2;
    localparam int CountWidth   = 8;
    localparam int DivPreWidth  = 6;
    localparam int TimPreWidth  = 8;
    localparam int SelWidth     = 2;
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 8;
    localparam int OutDataWidth = 2 * CountWidth;

    // timer sum: ticks plus a remainder of up to 255
    localparam int TimSumWidth  = TimPreWidth + 1;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_TIMER_ENABLE = 2'd0,
        REG_CLOCK_SELECT = 2'd1,
        REG_RELOAD_VALUE = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [SelWidth-1:0] {
        SEL_256 = 2'd0,
        SEL_4   = 2'd1,
        SEL_16  = 2'd2,
        SEL_64  = 2'd3
    } clk_sel_t;

    typedef struct packed {
        logic                  timer_enable;
        clk_sel_t              timer_rate;
        logic [CountWidth-1:0] reload_value;
    } cfg_t;

    typedef struct packed {
        logic                  timer_interrupt;
        logic [CountWidth-1:0] timer_value;
        logic [CountWidth-1:0] divider_value;
    } res_t;

    // log2 of the timer period in ticks
    function automatic logic [3:0] rate_shift(input clk_sel_t sel);
        logic [3:0] sh;
        case (sel)
            SEL_256: sh = 4'd8;
            SEL_4:   sh = 4'd2;
            SEL_16:  sh = 4'd4;
            SEL_64:  sh = 4'd6;
            default: sh = 4'd8;
        endcase
        return sh;
    endfunction

endpackage

// File: rtl/hdt_cfg.sv
module hdt_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [hdt_pkg::CfgIdxWidth-1:0]   wr_index,
    input  logic [hdt_pkg::CfgDataWidth-1:0]  wr_data,
    output hdt_pkg::cfg_t                     cfg
);

    hdt_pkg::cfg_t cfg_reg;
    hdt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (hdt_pkg::cfg_index_t'(wr_index))
                hdt_pkg::REG_TIMER_ENABLE: cfg_next.timer_enable = wr_data[0];
                hdt_pkg::REG_CLOCK_SELECT:
                    cfg_next.timer_rate = hdt_pkg::clk_sel_t'(wr_data[1:0]);
                hdt_pkg::REG_RELOAD_VALUE: cfg_next.reload_value = wr_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/hdt_core.sv
module hdt_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [hdt_pkg::CycleWidth-1:0]  cycle_count,
    input  hdt_pkg::cfg_t                   cfg,
    output hdt_pkg::res_t                   res
);

    logic [hdt_pkg::CountWidth-1:0]  div_cnt_reg, div_cnt_next;
    logic [hdt_pkg::DivPreWidth-1:0] div_pre_reg, div_pre_next;
    logic [hdt_pkg::CountWidth-1:0]  tim_cnt_reg, tim_cnt_next;
    logic [hdt_pkg::TimPreWidth-1:0] tim_pre_reg, tim_pre_next;

    logic [hdt_pkg::TickWidth-1:0]    ticks;
    logic [hdt_pkg::DivPreWidth:0]    div_sum;
    logic [hdt_pkg::TimSumWidth-1:0]  tim_sum;
    logic [hdt_pkg::TimSumWidth-1:0]  tim_quot;
    logic [hdt_pkg::TimSumWidth-1:0]  tim_mask;
    logic [hdt_pkg::TimSumWidth-1:0]  tim_adv;
    logic [3:0]                       sh;
    logic                             irq;

    assign ticks   = cycle_count[hdt_pkg::CycleWidth-1:2];
    assign div_sum = {1'b0, div_pre_reg} + {1'b0, ticks};
    assign tim_sum = {1'b0, tim_pre_reg}
                   + {{(hdt_pkg::TimSumWidth-hdt_pkg::TickWidth){1'b0}}, ticks};
    assign sh       = hdt_pkg::rate_shift(cfg.timer_rate);
    assign tim_quot = tim_sum >> sh;
    assign tim_mask = ~({hdt_pkg::TimSumWidth{1'b1}} << sh);
    assign tim_adv  = {1'b0, tim_cnt_reg} + tim_quot;

    always_comb
    begin
        div_pre_next = div_sum[hdt_pkg::DivPreWidth-1:0];
        div_cnt_next = div_cnt_reg
                     + {{(hdt_pkg::CountWidth-1){1'b0}}, div_sum[hdt_pkg::DivPreWidth]};
        tim_pre_next = tim_pre_reg;
        tim_cnt_next = tim_cnt_reg;
        irq          = 1'b0;
        if (cfg.timer_enable)
        begin
            tim_pre_next = tim_sum[hdt_pkg::TimPreWidth-1:0]
                         & tim_mask[hdt_pkg::TimPreWidth-1:0];
            if (tim_adv[hdt_pkg::CountWidth])
            begin
                // overflow: reload plus the excess past 256
                tim_cnt_next = cfg.reload_value + tim_adv[hdt_pkg::CountWidth-1:0];
                irq          = 1'b1;
            end
            else
            begin
                tim_cnt_next = tim_adv[hdt_pkg::CountWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            div_pre_reg <= '0;
            tim_cnt_reg <= '0;
            tim_pre_reg <= '0;
        end
        else if (step)
        begin
            div_cnt_reg <= div_cnt_next;
            div_pre_reg <= div_pre_next;
            tim_cnt_reg <= tim_cnt_next;
            tim_pre_reg <= tim_pre_next;
        end
    end

    assign res.divider_value   = div_cnt_next;
    assign res.timer_value     = tim_cnt_next;
    assign res.timer_interrupt = irq;

endmodule

// File: rtl/handheld_divider_and_timer.sv
// Divider and programmable timer. Each transaction on s_* carries a batch of
// machine cycles (four per tick); each yields one transaction on m_* with the
// divider and timer counters after the batch and an overflow flag in m_tuser.
// The block takes one transaction per cycle unless m_tready stalls it: an
// input register feeds a single update of the counter state, and the result
// lands in an output register. Write the cfg registers (0 enable, 1 clock
// select, 2 reload value) only while idle.
module handheld_divider_and_timer
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hdt_pkg::CycleWidth-1:0]       s_tdata,   // [7:0] cycle_count

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hdt_pkg::OutDataWidth-1:0]     m_tdata,   // [7:0] divider_value,
                                                            // [15:8] timer_value
    output logic                                 m_tuser,   // timer_interrupt

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hdt_pkg::CfgIdxWidth-1:0]      cfg_index,
    input  logic [hdt_pkg::CfgDataWidth-1:0]     cfg_data
);

    hdt_pkg::cfg_t cfg;
    hdt_pkg::res_t res;

    logic                            in_valid_reg, in_valid_next;
    logic [hdt_pkg::CycleWidth-1:0]  in_data_reg;
    logic                            out_valid_reg, out_valid_next;
    hdt_pkg::res_t                   out_data_reg;
    logic                            out_ready;
    logic                            step;

    assign cfg_ready = 1'b1;

    hdt_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hdt_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cycle_count (in_data_reg),
        .cfg         (cfg),
        .res         (res)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.timer_value, out_data_reg.divider_value};
    assign m_tuser  = out_data_reg.timer_interrupt;

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hdt_pkg::*;

    typedef enum bit {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // idx is used by ROW_CFG rows only; want applies only when typed is set
    typedef struct {
        row_kind_t  kind;
        cfg_index_t idx;
        logic [7:0] val;
        int         reps;
        bit         typed;
        res_t       want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;

    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [CycleWidth-1:0]      s_tdata = '0;

    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OutDataWidth-1:0]    m_tdata;
    logic                       m_tuser;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_index_t                 cfg_index = REG_TIMER_ENABLE;
    logic [CfgDataWidth-1:0]    cfg_data = '0;

    // shadow of the block's registers and counters
    logic                       tim_enable = 1'b0;
    clk_sel_t                   tim_select = SEL_256;
    logic [CountWidth-1:0]      tim_reload = '0;
    logic [CountWidth-1:0]      div_total = '0;
    logic [DivPreWidth-1:0]     div_remainder = '0;
    logic [CountWidth-1:0]      tim_count = '0;
    logic [TimPreWidth-1:0]     tim_remainder = '0;

    res_t                       expected_counts[$];
    int                         mismatches = 0;
    bit                         src_burst = 1'b0;
    bit                         sink_burst = 1'b0;
    bit                         hold_req = 1'b0;

    stim_row_t directed[] = '{
        // reset state, timer off
        '{ROW_ITEM, REG_UNUSED,       8'd0,   1,  1'b1, '{1'b0, 8'd0, 8'd0}},
        '{ROW_ITEM, REG_UNUSED,       8'd3,   1,  1'b1, '{1'b0, 8'd0, 8'd0}},
        '{ROW_ITEM, REG_UNUSED,       8'd255, 1,  1'b1, '{1'b0, 8'd0, 8'd0}},
        '{ROW_ITEM, REG_UNUSED,       8'd4,   1,  1'b1, '{1'b0, 8'd0, 8'd1}},
        // write to the unused index must be dropped
        '{ROW_CFG,  REG_UNUSED,       8'hFF,  1,  1'b0, '0},
        '{ROW_CFG,  REG_CLOCK_SELECT, 8'd0,   1,  1'b0, '0},
        '{ROW_CFG,  REG_TIMER_ENABLE, 8'd1,   1,  1'b0, '0},
        // build a large remainder at the slowest rate
        '{ROW_ITEM, REG_UNUSED,       8'd255, 4,  1'b0, '0},
        '{ROW_CFG,  REG_CLOCK_SELECT, 8'd1,   1,  1'b0, '0},
        '{ROW_ITEM, REG_UNUSED,       8'd255, 1,  1'b0, '0},
        '{ROW_CFG,  REG_RELOAD_VALUE, 8'hFF,  1,  1'b0, '0},
        // run through an overflow
        '{ROW_ITEM, REG_UNUSED,       8'd255, 12, 1'b0, '0},
        '{ROW_CFG,  REG_CLOCK_SELECT, 8'd2,   1,  1'b0, '0},
        '{ROW_ITEM, REG_UNUSED,       8'd255, 2,  1'b0, '0},
        '{ROW_CFG,  REG_CLOCK_SELECT, 8'd3,   1,  1'b0, '0},
        '{ROW_ITEM, REG_UNUSED,       8'd252, 2,  1'b0, '0},
        // disabled timer holds its count
        '{ROW_CFG,  REG_TIMER_ENABLE, 8'd0,   1,  1'b0, '0},
        '{ROW_ITEM, REG_UNUSED,       8'd255, 1,  1'b0, '0}
    };

    handheld_divider_and_timer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic res_t predict_counters(input logic [CycleWidth-1:0] cycles);
        int   ticks;
        int   period;
        int   sum;
        int   nxt;
        res_t r;
        ticks = int'(cycles) >> 2;
        sum = ticks + int'(div_remainder);
        div_remainder = 6'(sum % 64);
        div_total = 8'(int'(div_total) + sum / 64);
        r.timer_interrupt = 1'b0;
        if (tim_enable)
        begin
            case (tim_select)
                SEL_4:   period = 4;
                SEL_16:  period = 16;
                SEL_64:  period = 64;
                default: period = 256;
            endcase
            sum = ticks + int'(tim_remainder);
            tim_remainder = 8'(sum % period);
            nxt = int'(tim_count) + sum / period;
            if (nxt > 255)
            begin
                // reload plus excess, wrapped to 8 bits
                tim_count = 8'(int'(tim_reload) + nxt - 256);
                r.timer_interrupt = 1'b1;
            end
            else
            begin
                tim_count = 8'(nxt);
            end
        end
        r.divider_value = div_total;
        r.timer_value = tim_count;
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TIMER_ENABLE: tim_enable = val[0];
            REG_CLOCK_SELECT: tim_select = clk_sel_t'(val[1:0]);
            REG_RELOAD_VALUE: tim_reload = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(input logic [CycleWidth-1:0] cycles, input bit typed,
                             input res_t want);
        int   gap;
        res_t r;
        gap = src_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cycles;
        do @(posedge clk); while (!s_tready);
        r = predict_counters(cycles);
        expected_counts.push_back(typed ? want : r);
    endtask

    task automatic check_result(input logic [OutDataWidth-1:0] data, input logic irq);
        res_t want;
        if (expected_counts.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transaction: div %0d timer %0d irq %b",
                         data[7:0], data[15:8], irq);
            return;
        end
        want = expected_counts.pop_front();
        if (data[7:0] !== want.divider_value || data[15:8] !== want.timer_value ||
            irq !== want.timer_interrupt)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp div %0d timer %0d irq %b, got div %0d timer %0d irq %b",
                         want.divider_value, want.timer_value, want.timer_interrupt,
                         data[7:0], data[15:8], irq);
        end
    endtask

    initial
    begin : sink
        int w;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                w = 80;
            end
            else
            begin
                w = sink_burst ? 0 : $urandom_range(0, 14);
            end
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin : stimulus
        int         ph;
        int         n;
        logic [7:0] val;
        logic [7:0] cycles;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(directed[i].idx, directed[i].val);
            end
            else
            begin
                repeat (directed[i].reps)
                    send_item(directed[i].val, directed[i].typed, directed[i].want);
            end
        end

        // first phase: long receiver stall while the sender streams back to back
        src_burst = 1'b1;
        hold_req = 1'b1;
        for (ph = 0; ph < 26; ph++)
        begin
            settle();
            val = 8'($urandom);
            val[0] = ($urandom_range(0, 4) != 0);
            write_reg(REG_TIMER_ENABLE, val);
            val = 8'($urandom);
            val[1:0] = 2'(ph % 4);
            write_reg(REG_CLOCK_SELECT, val);
            case (ph % 3)
                0: val = 8'h00;
                1: val = 8'hFF;
                default: val = 8'($urandom);
            endcase
            write_reg(REG_RELOAD_VALUE, val);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 8'($urandom));
            if (ph > 0)
            begin
                src_burst = ($urandom_range(0, 3) == 0);
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            for (n = 0; n < 50; n++)
            begin
                case ($urandom_range(0, 7))
                    0: cycles = 8'd255;
                    1: cycles = 8'($urandom_range(0, 7));
                    default: cycles = 8'($urandom_range(0, 255));
                endcase
                send_item(cycles, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
